[sv/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

[sv/sbssc_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sbssc_pkg
// Shared widths, register indexes, reset values and control types of the
// block size and strong length chooser.
// -----------------------------------------------------------------------------
package sbssc_pkg;

   localparam int unsigned LEN_W    = 64;
   localparam int unsigned HINT_W   = 32;
   localparam int unsigned BLK_W    = 32;
   localparam int unsigned DFLT_W   = 16;
   localparam int unsigned BIAS_W   = 6;
   localparam int unsigned STRONG_W = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BLOCK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DFLT_BLOCK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS       = 2'd2;

   // Reset values
   localparam logic [BLK_W-1:0]  MAX_BLOCK_RST  = 32'd131072;
   localparam logic [DFLT_W-1:0] DFLT_BLOCK_RST = 16'd700;
   localparam logic [BIAS_W-1:0] BIAS_RST       = 6'd10;

   // Strong length rule
   localparam logic [7:0]          STRONG_OFFSET = 8'd24;
   localparam logic [STRONG_W-1:0] STRONG_MIN    = 5'd2;
   localparam logic [STRONG_W-1:0] STRONG_MAX    = 5'd16;

   // Lowest root bit tried when the root starts above it
   localparam logic [4:0] ROOT_LOW_BIT = 5'd3;

   // Binary search for the leading one: shifts 32, 16, 8, 4, 2, 1
   localparam logic [2:0] SCAN_LAST = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_SIZE = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic size;
      logic root_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic skip_root;
      logic root_done;
      logic out_free;
   } sts_type;

endpackage

[sv/sbssc_ctrl.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sbssc_ctrl
// Sequencer: steps the datapath through leading-one scan, sizing, the
// bit-serial root and the hand-off to the result register.
// -----------------------------------------------------------------------------
module sbssc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sbssc_pkg::sts_type sts,
   output sbssc_pkg::cmd_type cmd
);

   sbssc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sbssc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sbssc_pkg::ST_SCAN;
            end
         end
         sbssc_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = sbssc_pkg::ST_SIZE;
            end
         end
         sbssc_pkg::ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = sbssc_pkg::ST_ROOT;
         end
         sbssc_pkg::ST_ROOT: begin
            if (sts.skip_root) begin
               state_in = sbssc_pkg::ST_EMIT;
            end else begin
               cmd.root_step = 1'b1;
               if (sts.root_done) begin
                  state_in = sbssc_pkg::ST_EMIT;
               end
            end
         end
         sbssc_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sbssc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbssc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbssc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/sbssc_dpath.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sbssc_dpath
// Datapath: operand capture, leading-one search, strong length, bit-serial
// square root with a running square, and the result register.
// -----------------------------------------------------------------------------
module sbssc_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbssc_pkg::cmd_type                   cmd,
   output sbssc_pkg::sts_type                   sts,
   input  logic [sbssc_pkg::LEN_W-1:0]          req_file_length,
   input  logic [sbssc_pkg::HINT_W-1:0]         req_block_length_hint,
   input  logic [sbssc_pkg::BLK_W-1:0]          max_block,
   input  logic [sbssc_pkg::DFLT_W-1:0]         dflt_block,
   input  logic [sbssc_pkg::BIAS_W-1:0]         bias,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [sbssc_pkg::BLK_W-1:0]          rsp_block_length,
   output logic [sbssc_pkg::STRONG_W-1:0]       rsp_strong_length
);

   // Operands and scan state
   logic [sbssc_pkg::LEN_W-1:0]    len_ff;
   logic [sbssc_pkg::LEN_W-1:0]    lval_ff, lval_in;
   logic [sbssc_pkg::HINT_W-1:0]   hval_ff, hval_in;
   logic [5:0]                     lmsb_ff, lmsb_in;
   logic [4:0]                     hmsb_ff, hmsb_in;
   logic [2:0]                     step_ff;
   logic [31:0]                    dsq_ff;

   // Sizing and root state
   logic                           skip_ff;
   logic [sbssc_pkg::BLK_W-1:0]    blk_ff, blk_in;
   logic [sbssc_pkg::STRONG_W-1:0] strong_ff, strong_in;
   logic [sbssc_pkg::BLK_W-1:0]    root_ff;
   logic [sbssc_pkg::LEN_W-1:0]    sq_ff;
   logic [4:0]                     bit_ff;

   // Result register
   logic                           rsp_valid_ff;
   logic [sbssc_pkg::BLK_W-1:0]    rsp_blk_ff;
   logic [sbssc_pkg::STRONG_W-1:0] rsp_strong_ff;

   logic [5:0]                     shamt;
   logic [4:0]                     root_k;
   logic [sbssc_pkg::BLK_W-1:0]    c_val;
   logic                           small_len;
   logic                           cap_hit;
   logic [7:0]                     bsum, bnet, bdiff;
   logic [sbssc_pkg::STRONG_W-1:0] quo;
   logic [64:0]                    trial;
   logic                           trial_ok;
   logic [sbssc_pkg::BLK_W-1:0]    root_final;

   // Leading-one search: halve the window each step
   always_comb begin
      shamt   = 6'(6'd32 >> step_ff);
      lval_in = lval_ff;
      lmsb_in = lmsb_ff;
      hval_in = hval_ff;
      hmsb_in = hmsb_ff;
      if ((lval_ff >> shamt) != '0) begin
         lval_in = lval_ff >> shamt;
         lmsb_in = lmsb_ff + shamt;
      end
      if ((hval_ff >> shamt) != '0) begin
         hval_in = hval_ff >> shamt;
         hmsb_in = hmsb_ff + shamt[4:0];
      end
   end

   // Sizing: small-file and cap checks, strong length
   always_comb begin
      root_k    = lmsb_ff[5:1];
      c_val     = 32'(1) << root_k;
      small_len = len_ff <= {32'd0, dsq_ff};
      cap_hit   = c_val >= max_block;
      bsum      = 8'(bias) + {1'b0, lmsb_ff, 1'b0};
      bnet      = (bsum > 8'(hmsb_ff)) ? (bsum - 8'(hmsb_ff)) : 8'd0;
      bdiff     = bnet - sbssc_pkg::STRONG_OFFSET;
      quo       = bdiff[7:3];
      if (bnet < sbssc_pkg::STRONG_OFFSET || quo < sbssc_pkg::STRONG_MIN) begin
         strong_in = sbssc_pkg::STRONG_MIN;
      end else if (quo > sbssc_pkg::STRONG_MAX) begin
         strong_in = sbssc_pkg::STRONG_MAX;
      end else begin
         strong_in = quo;
      end
      if (small_len) begin
         blk_in = 32'(dflt_block);
      end else begin
         blk_in = max_block;
      end
   end

   // Root trial: (root + 2^j)^2 = sq + root*2^(j+1) + 2^(2j); the two
   // added terms never overlap, so OR them
   always_comb begin
      trial    = {1'b0, sq_ff}
                 + (({33'd0, root_ff} << (bit_ff + 5'd1)) | (65'd1 << {bit_ff, 1'b0}));
      trial_ok = trial <= {1'b0, len_ff};
   end

   assign root_final = (root_ff > 32'(dflt_block)) ? root_ff : 32'(dflt_block);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff  <= req_file_length;
         lval_ff <= req_file_length;
         hval_ff <= req_block_length_hint;
         lmsb_ff <= '0;
         hmsb_ff <= '0;
         step_ff <= '0;
         dsq_ff  <= 32'(dflt_block) * 32'(dflt_block);
      end else if (cmd.scan_step) begin
         lval_ff <= lval_in;
         hval_ff <= hval_in;
         lmsb_ff <= lmsb_in;
         hmsb_ff <= hmsb_in;
         step_ff <= step_ff + 3'd1;
      end
      if (cmd.size) begin
         skip_ff   <= small_len || cap_hit;
         blk_ff    <= blk_in;
         strong_ff <= strong_in;
         root_ff   <= '0;
         sq_ff     <= '0;
         bit_ff    <= root_k;
      end else if (cmd.root_step) begin
         if (trial_ok) begin
            root_ff[bit_ff] <= 1'b1;
            sq_ff           <= trial[63:0];
         end
         bit_ff <= bit_ff - 5'd1;
      end
      if (cmd.emit) begin
         rsp_blk_ff    <= skip_ff ? blk_ff : root_final;
         rsp_strong_ff <= strong_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      sts.scan_done = step_ff == sbssc_pkg::SCAN_LAST;
      sts.skip_root = skip_ff;
      sts.root_done = bit_ff <= sbssc_pkg::ROOT_LOW_BIT;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_length  = rsp_blk_ff;
   assign rsp_strong_length = rsp_strong_ff;

endmodule

[sv/sync_block_and_strong_size_chooser.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sync_block_and_strong_size_chooser
// Picks the block length and strong checksum length for a file signature.
// -----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_ready  file length, block length hint
// rsp_      out        rsp_valid/rsp_ready  block length, strong length
// csr_      in         csr_valid/csr_ready  register index, write data
//
// An item goes from accept through six steps of the leading-one search, one
// sizing step, one root step per root bit (bits floor(log4 len) down to 3,
// up to 29) or one skip step when the file is small or the cap applies, and
// then into the result register. The bit-serial root loop sets the worst
// case. Reset restores the registers to their default values and empties
// the result register. A new word is taken while a finished result waits on
// rsp_ready; a stalled result holds only the final hand-off.
//
module sync_block_and_strong_size_chooser (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [sbssc_pkg::LEN_W-1:0]            req_file_length,
   input  logic [sbssc_pkg::HINT_W-1:0]           req_block_length_hint,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sbssc_pkg::BLK_W-1:0]            rsp_block_length,
   output logic [sbssc_pkg::STRONG_W-1:0]         rsp_strong_length,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sbssc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sbssc_pkg::CSR_DAT_W-1:0]        csr_wdata
);

`include "assert_macros.svh"

   // Configuration registers
   logic [sbssc_pkg::BLK_W-1:0]  max_block_ff;
   logic [sbssc_pkg::DFLT_W-1:0] dflt_block_ff;
   logic [sbssc_pkg::BIAS_W-1:0] bias_ff;

   sbssc_pkg::cmd_type cmd;
   sbssc_pkg::sts_type sts;

   // Always take register writes; an unknown index is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_block_ff  <= sbssc_pkg::MAX_BLOCK_RST;
         dflt_block_ff <= sbssc_pkg::DFLT_BLOCK_RST;
         bias_ff       <= sbssc_pkg::BIAS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            sbssc_pkg::CSR_MAX_BLOCK:  max_block_ff  <= csr_wdata;
            sbssc_pkg::CSR_DFLT_BLOCK: dflt_block_ff <= csr_wdata[sbssc_pkg::DFLT_W-1:0];
            sbssc_pkg::CSR_BIAS:       bias_ff       <= csr_wdata[sbssc_pkg::BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   sbssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and result register
   sbssc_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_file_length       (req_file_length),
      .req_block_length_hint (req_block_length_hint),
      .max_block             (max_block_ff),
      .dflt_block            (dflt_block_ff),
      .bias                  (bias_ff),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_block_length      (rsp_block_length),
      .rsp_strong_length     (rsp_strong_length)
   );

   // Strong length always lands in its clamp range
   `ASSERT_NEVER(a_strong_range, clock, reset,
                 rsp_valid && (rsp_strong_length < sbssc_pkg::STRONG_MIN
                               || rsp_strong_length > sbssc_pkg::STRONG_MAX))
   // After a word is taken the sequencer is busy on the next cycle
   `ASSERT_ALWAYS(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready)
   // A new result is only loaded from the final hand-off, never from idle
   `ASSERT_ALWAYS(a_emit_not_idle, clock, reset, $rose(rsp_valid) |-> !$past(req_ready))

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the block size and strong length chooser.
// A directed table covers reset values, field extremes, register masking and
// the corner cases of both rules. Several register settings then each get a
// batch of random words, with lengths spread evenly over their bit widths
// and clustered around D*D and perfect squares. Every result is compared
// field by field with a typed-in value or an in-bench model of both rules.
// -----------------------------------------------------------------------------
module tb;

   // Index past the end of the register list; writes to it must be dropped
   localparam logic [sbssc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Words per register setting in the random part
   localparam int unsigned PHASE_WORDS = 115;
   localparam int unsigned PHASES      = 8;
   // Phase in which the result side holds off long enough to back up the input
   localparam int unsigned HOLD_PHASE  = 5;
   localparam int unsigned HOLD_CYCLES = 600;

   typedef struct packed {
      logic [sbssc_pkg::BLK_W-1:0]    blk;
      logic [sbssc_pkg::STRONG_W-1:0] strong_len;
   } sizes_type;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   // One line of the directed table. A write row carries the register index
   // in the length column and the write data in the hint column.
   typedef struct packed {
      row_kind_type                   kind;
      logic [sbssc_pkg::LEN_W-1:0]    len_or_index;
      logic [sbssc_pkg::HINT_W-1:0]   hint_or_data;
      logic                           typed;
      logic [sbssc_pkg::BLK_W-1:0]    blk;
      logic [sbssc_pkg::STRONG_W-1:0] strong_len;
   } stim_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [sbssc_pkg::LEN_W-1:0]       req_file_length = '0;
   logic [sbssc_pkg::HINT_W-1:0]      req_block_length_hint = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [sbssc_pkg::BLK_W-1:0]       rsp_block_length;
   logic [sbssc_pkg::STRONG_W-1:0]    rsp_strong_length;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [sbssc_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [sbssc_pkg::CSR_DAT_W-1:0]   csr_wdata = '0;

   // Shadow copy of the registers, updated when a write is accepted
   logic [sbssc_pkg::BLK_W-1:0]       cfg_max  = sbssc_pkg::MAX_BLOCK_RST;
   logic [sbssc_pkg::DFLT_W-1:0]      cfg_dflt = sbssc_pkg::DFLT_BLOCK_RST;
   logic [sbssc_pkg::BIAS_W-1:0]      cfg_bias = sbssc_pkg::BIAS_RST;

   sizes_type              pending_sizes[$];
   int unsigned            failures = 0;
   int unsigned            idle_pct = 30;
   logic                   hold_rsp = 1'b0;
   logic                   held_long = 1'b0;
   int unsigned            stall_left = 0;

   always #5 clock = ~clock;

   sync_block_and_strong_size_chooser dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_file_length       (req_file_length),
      .req_block_length_hint (req_block_length_hint),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_block_length      (rsp_block_length),
      .rsp_strong_length     (rsp_strong_length),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // Directed table: reset values first, then the special register settings.
   // Expected values are typed in only where they are obvious; the other
   // rows go through the model.
   stim_row_type directed_rows [30] = '{
      // Reset settings: tiny files, the D*D boundary, the largest lengths
      '{ROW_ITEM, 64'd0, 32'd0, 1'b1, 32'd700, 5'd2},
      '{ROW_ITEM, 64'd1, 32'd1, 1'b1, 32'd700, 5'd2},
      '{ROW_ITEM, 64'd490000, 32'hFFFF_FFFF, 1'b1, 32'd700, 5'd2},
      '{ROW_ITEM, 64'd490001, 32'd0, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, 32'd131072, 5'd14},
      '{ROW_ITEM, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd131072, 5'd10},
      // Root start exactly at the cap, then one below it
      '{ROW_ITEM, 64'h4_0000_0000, 32'd0, 1'b1, 32'd131072, 5'd6},
      '{ROW_ITEM, 64'h3_FFFF_FFFF, 32'd1, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0, 5'd0},
      // A write past the register list changes nothing
      '{ROW_CSR, 64'(CSR_SPARE), 32'hFFFF_FFFF, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, 32'd131072, 5'd14},
      // All zero; the upper write bits must be masked off
      '{ROW_CSR, 64'(sbssc_pkg::CSR_MAX_BLOCK), 32'd0, 1'b0, 32'd0, 5'd0},
      '{ROW_CSR, 64'(sbssc_pkg::CSR_DFLT_BLOCK), 32'hFFFF_0000, 1'b0, 32'd0, 5'd0},
      '{ROW_CSR, 64'(sbssc_pkg::CSR_BIAS), 32'hFFFF_FFC0, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'd0, 32'd0, 1'b1, 32'd0, 5'd2},
      '{ROW_ITEM, 64'd5, 32'hFFFF_FFFF, 1'b1, 32'd0, 5'd2},
      // Widest cap, smallest default, largest bias: roots below bit 3
      '{ROW_CSR, 64'(sbssc_pkg::CSR_MAX_BLOCK), 32'hFFFF_FFFF, 1'b0, 32'd0, 5'd0},
      '{ROW_CSR, 64'(sbssc_pkg::CSR_DFLT_BLOCK), 32'd1, 1'b0, 32'd0, 5'd0},
      '{ROW_CSR, 64'(sbssc_pkg::CSR_BIAS), 32'd63, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'd50, 32'd0, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'd63, 32'd3, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, 32'hFFFF_FFF8, 5'd16},
      // Default above the cap
      '{ROW_CSR, 64'(sbssc_pkg::CSR_MAX_BLOCK), 32'd600, 1'b0, 32'd0, 5'd0},
      '{ROW_CSR, 64'(sbssc_pkg::CSR_DFLT_BLOCK), 32'd1000, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'd1000001, 32'd0, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'd1048576, 32'd0, 1'b0, 32'd0, 5'd0},
      // Largest default, lengths right at and past its square
      '{ROW_CSR, 64'(sbssc_pkg::CSR_DFLT_BLOCK), 32'd65535, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'd4294836225, 32'd0, 1'b0, 32'd0, 5'd0},
      '{ROW_ITEM, 64'd4294836226, 32'd0, 1'b0, 32'd0, 5'd0}
   };

   // Block length and strong length for one word under the shadow registers
   function automatic sizes_type choose_sizes(input logic [sbssc_pkg::LEN_W-1:0] len,
                                              input logic [sbssc_pkg::HINT_W-1:0] hint);
      sizes_type                   r;
      logic [sbssc_pkg::LEN_W-1:0] l;
      logic [31:0]                 c;
      logic [31:0]                 root;
      logic [31:0]                 h;
      int                          b;
      int                          s;

      if (len <= 64'(cfg_dflt) * 64'(cfg_dflt)) begin
         r.blk = 32'(cfg_dflt);
      end else begin
         // Root start: 2^floor(log4 len)
         c = 32'd1;
         l = len >> 2;
         while (l != 0) begin
            c = c << 1;
            l = l >> 2;
         end
         if (c >= cfg_max) begin
            r.blk = cfg_max;
         end else begin
            // Keep each bit whose square still fits; always try the start bit
            root = '0;
            do begin
               root = root | c;
               if (len < 64'(root) * 64'(root))
                  root = root & ~c;
               c = c >> 1;
            end while (c >= 32'd8);
            r.blk = (root > 32'(cfg_dflt)) ? root : 32'(cfg_dflt);
         end
      end

      // Bias plus twice log2 of the length, less log2 of the hint, floor at 0
      b = int'(cfg_bias);
      l = len >> 1;
      while (l != 0) begin
         b += 2;
         l = l >> 1;
      end
      h = hint >> 1;
      while (h != 0 && b > 0) begin
         b--;
         h = h >> 1;
      end
      s = (b - 24) / 8;
      if (s < 2)
         s = 2;
      if (s > 16)
         s = 16;
      r.strong_len = s[sbssc_pkg::STRONG_W-1:0];
      return r;
   endfunction

   // Append one expected result behind the ones still outstanding
   function automatic void queue_expected(input sizes_type sizes);
      pending_sizes.insert(pending_sizes.size(), sizes);
   endfunction

   // Idle length: most short, a few long, none at all when idle_pct is zero
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) >= idle_pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // Value of k random bits, with k uniform over 0..bits
   function automatic logic [63:0] log_spread(input int unsigned bits);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw >> (64 - $urandom_range(0, bits));
   endfunction

   function automatic logic [sbssc_pkg::LEN_W-1:0] pick_file_length();
      logic [63:0] sq;
      logic [63:0] r;
      sq = 64'(cfg_dflt) * 64'(cfg_dflt);
      r  = log_spread(32);
      case ($urandom_range(0, 9))
         0: return sq + 64'($urandom_range(0, 2)) - 64'd1;
         1: return r * r + 64'($urandom_range(0, 2)) - 64'd1;
         2: return {$urandom, $urandom};
         default: return log_spread(64);
      endcase
   endfunction

   // Offer one word and hold it until taken; leave valid high for the next
   task automatic send_word(input logic [sbssc_pkg::LEN_W-1:0] len,
                            input logic [sbssc_pkg::HINT_W-1:0] hint,
                            input logic typed, input sizes_type given);
      csr_valid             <= 1'b0;
      req_valid             <= 1'b1;
      req_file_length       <= len;
      req_block_length_hint <= hint;
      do @(posedge clock); while (!req_ready);
      queue_expected(typed ? given : choose_sizes(len, hint));
   endtask

   task automatic rest_req(input int unsigned cycles);
      if (cycles != 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic settle_words();
      req_valid <= 1'b0;
      while (pending_sizes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [sbssc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sbssc_pkg::CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sbssc_pkg::CSR_MAX_BLOCK:  cfg_max  = data;
         sbssc_pkg::CSR_DFLT_BLOCK: cfg_dflt = data[sbssc_pkg::DFLT_W-1:0];
         sbssc_pkg::CSR_BIAS:       cfg_bias = data[sbssc_pkg::BIAS_W-1:0];
         default:        ;  // unknown index: drop the write
      endcase
   endtask

   // Result side: random hold-offs, one long hold when asked, and the check
   always @(posedge clock) begin : result_side
      sizes_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_sizes.size() == 0) begin
               $error("unexpected result: block_length %0d strong_length %0d",
                      rsp_block_length, rsp_strong_length);
               failures++;
            end else begin
               want = pending_sizes.pop_front();
               if (rsp_block_length !== want.blk) begin
                  $error("block_length: expected %0d, actual %0d", want.blk, rsp_block_length);
                  failures++;
               end
               if (rsp_strong_length !== want.strong_len) begin
                  $error("strong_length: expected %0d, actual %0d",
                         want.strong_len, rsp_strong_length);
                  failures++;
               end
            end
         end
         // Long hold: the block fills up and must stall its input
         if (hold_rsp && !held_long) begin
            held_long  <= 1'b1;
            stall_left <= HOLD_CYCLES;
            rsp_ready  <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left <= pick_gap();
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      sizes_type    given;
      logic [31:0]  new_max;
      logic [15:0]  new_dflt;
      logic [5:0]   new_bias;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            settle_words();
            write_reg(row.len_or_index[sbssc_pkg::CSR_IDX_W-1:0], row.hint_or_data);
         end else begin
            given.blk        = row.blk;
            given.strong_len = row.strong_len;
            send_word(row.len_or_index, row.hint_or_data, row.typed, given);
            rest_req(pick_gap());
         end
      end

      // Random part: one batch of words per register setting
      for (int unsigned ph = 0; ph < PHASES; ph++) begin
         settle_words();
         case (ph)
            0: begin
               new_max  = sbssc_pkg::MAX_BLOCK_RST;
               new_dflt = sbssc_pkg::DFLT_BLOCK_RST;
               new_bias = sbssc_pkg::BIAS_RST;
            end
            1: begin
               new_max = '1; new_dflt = '1; new_bias = '1;
            end
            2: begin
               new_max = '0; new_dflt = '0; new_bias = '0;
            end
            3: begin
               new_max = 32'd1; new_dflt = 16'd1; new_bias = 6'd1;
            end
            default: begin
               new_max  = 32'(log_spread(32));
               new_dflt = 16'(log_spread(16));
               new_bias = 6'($urandom_range(0, 63));
            end
         endcase
         // Random upper bits must be masked away by the block
         write_reg(sbssc_pkg::CSR_MAX_BLOCK, new_max);
         write_reg(sbssc_pkg::CSR_DFLT_BLOCK, {16'($urandom), new_dflt});
         write_reg(sbssc_pkg::CSR_BIAS, {26'($urandom), new_bias});
         if ($urandom_range(0, 1) != 0)
            write_reg(CSR_SPARE, $urandom);

         // Calm phases give stretches with no idling on either side, but for the long hold
         idle_pct = (ph == 0 || ph == HOLD_PHASE) ? 0 : $urandom_range(10, 60);
         hold_rsp = (ph == HOLD_PHASE);

         given = '0;
         repeat (PHASE_WORDS) begin
            send_word(pick_file_length(), 32'(log_spread(32)), 1'b0, given);
            rest_req(pick_gap());
         end
      end

      settle_words();
      // Allow a full item time for any stray result to show up
      repeat (50) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/sbssc_pkg.sv
sv/sbssc_ctrl.sv
sv/sbssc_dpath.sv
sv/sync_block_and_strong_size_chooser.sv
tb/tb.sv
